### rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Types, character codes and the per-byte decision function shared by the
// comment strip tokenizer modules.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int MaxResults = 4;
  localparam int RunIdxW    = 2;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2,
    MODE_CLOSED = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  skip_next;
    logic  word_open;
    logic  text_ended;
  } tok_state_t;

  localparam tok_state_t TokReset = '{
    mode: MODE_NONE, skip_next: 1'b0, word_open: 1'b0, text_ended: 1'b0
  };

  typedef struct packed {
    tok_state_t st;
    logic       emit;
    logic       starts;
  } decide_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       starts_token;
    logic       end_of_text;
  } result_t;

  // One queue entry: all words caused by one accepted input item.
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [RunIdxW-1:0]       last_idx;
  } run_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic fresh;
  } front_stat_t;

  // Decide byte c with lookahead n1, n2.
  function automatic decide_t decide(tok_state_t st, logic [7:0] c,
                                     logic [7:0] n1, logic [7:0] n2);
    decide_t d;
    d.st     = st;
    d.emit   = 1'b0;
    d.starts = 1'b0;
    if (st.skip_next) begin
      d.st.skip_next = 1'b0;
    end else begin
      if (c == ChSlash) begin
        if (n1 == ChSlash && n2 != ChHash && d.st.mode == MODE_NONE) d.st.mode = MODE_LINE;
        if (n1 == ChStar && d.st.mode == MODE_NONE) d.st.mode = MODE_BLOCK;
      end else if (c == ChStar) begin
        if (n1 == ChSlash && d.st.mode == MODE_BLOCK) begin
          d.st.mode      = MODE_CLOSED;
          d.st.skip_next = 1'b1;
        end
      end else if (c == ChLf) begin
        if (d.st.mode == MODE_LINE) d.st.mode = MODE_NONE;
      end
      if (d.st.mode == MODE_NONE && !d.st.text_ended) begin
        if (c == ChNul) begin
          d.st.text_ended = 1'b1;
          d.st.word_open  = 1'b0;
        end else if (c == ChSpace || c == ChLf || c == ChTab || c == ChCr) begin
          d.st.word_open = 1'b0;
        end else if (c == ChColon) begin
          d.st.word_open = 1'b0;
          d.emit         = 1'b1;
          d.starts       = 1'b1;
        end else begin
          d.emit         = 1'b1;
          d.starts       = !d.st.word_open;
          d.st.word_open = 1'b1;
        end
      end
      if (d.st.mode == MODE_CLOSED) d.st.mode = MODE_NONE;
    end
    return d;
  endfunction

endpackage

### rtl/core/cst_in_if.sv
// ----------------------------------------------------------------------------
// cst_in_if
// Text byte channel: valid/ready handshake with byte and final flag.
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

### rtl/core/cst_out_if.sv
// ----------------------------------------------------------------------------
// cst_out_if
// Token word channel: valid/ready handshake with token byte and marks.
// ----------------------------------------------------------------------------
interface cst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       starts_token;
  logic       end_of_text;
  logic       last_of_run;

  modport source (output valid, output token_byte, output starts_token,
                  output end_of_text, output last_of_run, input ready);
  modport sink (input valid, input token_byte, input starts_token,
                input end_of_text, input last_of_run, output ready);
endinterface

### rtl/core/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// Accepts text bytes, keeps the two-byte window and comment state, and packs
// the words each byte causes into one run for the queue.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic                 clk,
  input  logic                 rst,
  cst_in_if.sink               text_in,
  input  cst_pkg::q_stat_t     q_stat,
  output logic                 push,
  output cst_pkg::run_t        run,
  output cst_pkg::front_stat_t front_stat
);
  import cst_pkg::*;

  logic [7:0] win0, win1;
  logic [1:0] cnt;
  tok_state_t st;

  logic       accept;
  decide_t    single;
  run_t       flush_run;

  assign text_in.ready    = !q_stat.full;
  assign accept           = text_in.valid && text_in.ready;
  assign single           = decide(st, win0, win1, text_in.text_byte);
  assign front_stat.fresh = (cnt == 2'd0) && (st == TokReset);

  // Flush: decide every pending byte plus the final one, missing bytes as NUL.
  always_comb begin
    logic [7:0]         seq [5];
    logic [1:0]         len;
    logic [RunIdxW-1:0] k;
    tok_state_t         fs;
    decide_t            d;
    flush_run = '0;
    for (int j = 0; j < 5; j++) seq[j] = ChNul;
    unique case (cnt)
      2'd0: begin
        seq[0] = text_in.text_byte;
        len    = 2'd1;
      end
      2'd1: begin
        seq[0] = win0;
        seq[1] = text_in.text_byte;
        len    = 2'd2;
      end
      default: begin
        seq[0] = win0;
        seq[1] = win1;
        seq[2] = text_in.text_byte;
        len    = 2'd3;
      end
    endcase
    fs = st;
    k  = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < len) begin
        d  = decide(fs, seq[i], seq[i+1], seq[i+2]);
        fs = d.st;
        if (d.emit) begin
          flush_run.res[k] = '{token_byte: seq[i], starts_token: d.starts, end_of_text: 1'b0};
          k = k + 1'b1;
        end
      end
    end
    flush_run.res[k]   = '{token_byte: ChNul, starts_token: 1'b0, end_of_text: 1'b1};
    flush_run.last_idx = k;
  end

  always_comb begin
    if (text_in.final_byte) begin
      run  = flush_run;
      push = accept;
    end else begin
      run        = '0;
      run.res[0] = '{token_byte: win0, starts_token: single.starts, end_of_text: 1'b0};
      push       = accept && cnt[1] && single.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
      cnt  <= '0;
      st   <= TokReset;
    end else if (accept) begin
      if (text_in.final_byte) begin
        win0 <= '0;
        win1 <= '0;
        cnt  <= '0;
        st   <= TokReset;
      end else if (!cnt[1]) begin
        if (cnt == 2'd0) win0 <= text_in.text_byte;
        else win1 <= text_in.text_byte;
        cnt <= cnt + 2'd1;
      end else begin
        st   <= single.st;
        win0 <= win1;
        win1 <= text_in.text_byte;
      end
    end
  end

endmodule

### rtl/core/cst_queue.sv
// ----------------------------------------------------------------------------
// cst_queue
// Short run queue between front and back; head entry is read in place.
// ----------------------------------------------------------------------------
module cst_queue #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cst_pkg::run_t    push_run,
  input  logic             pop,
  output cst_pkg::run_t    head,
  output cst_pkg::q_stat_t q_stat
);
  import cst_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  run_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CntW'(Depth));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/core/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back
// Unpacks the head run into words, one per handshake, and pops it after the
// last word.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic             clk,
  input  logic             rst,
  input  cst_pkg::run_t    head,
  input  cst_pkg::q_stat_t q_stat,
  output logic             pop,
  cst_out_if.source        token_out
);
  import cst_pkg::*;

  logic [RunIdxW-1:0] idx;
  logic               last;
  logic               take;

  assign last                   = (idx == head.last_idx);
  assign take                   = token_out.valid && token_out.ready;
  assign pop                    = take && last;
  assign token_out.valid        = !q_stat.empty;
  assign token_out.token_byte   = head.res[idx].token_byte;
  assign token_out.starts_token = head.res[idx].starts_token;
  assign token_out.end_of_text  = head.res[idx].end_of_text;
  assign token_out.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

endmodule

### rtl/core/comment_strip_tokenizer.sv
// ----------------------------------------------------------------------------
// comment_strip_tokenizer
// Removes C-style comments from a byte stream and splits the rest into
// tokens, one word per kept byte plus an end marker per text.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle, every cycle, as long as its run
// queue has room. Each byte is decided against the two bytes that follow it,
// so words trail the input by two bytes: the first two bytes of a text give
// no word, later bytes give at most one, and the final byte flushes the
// window in the same cycle, giving up to three token words and the end
// marker (up to four words). The front stage does all decisions for one
// byte in its accept cycle and writes the resulting words as one run into a
// queue of QueueDepth runs; the back stage sends one word per cycle from the
// head run while the sink is ready. Input rate is one byte per cycle; output
// rate is one word per cycle while ready holds; flush words leave singly. Input
// stalls only when the queue is full: either the sink holds off ready, or
// flush runs arrive faster than their words can leave one per cycle.
// Line comments start at // unless # follows and keep their ending LF; block
// comments run to the next */ and /*/ closes at once. Space, LF, tab and CR
// split tokens, a colon is a token by itself, a kept NUL ends the text, and
// all state returns to reset after the final byte.
// ----------------------------------------------------------------------------
module comment_strip_tokenizer #(
  parameter int QueueDepth = 4
) (
  input logic       clk,
  input logic       rst,
  cst_in_if.sink    text_in,
  cst_out_if.source token_out
);
  import cst_pkg::*;

  logic        push;
  logic        pop;
  run_t        push_run;
  run_t        head;
  q_stat_t     q_stat;
  front_stat_t front_stat;

  // Accept and classify bytes; build the run each byte causes.
  cst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .q_stat     (q_stat),
    .push       (push),
    .run        (push_run),
    .front_stat (front_stat)
  );

  // Hold finished runs so the front keeps going while the sink stalls.
  cst_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Drain the head run one word at a time.
  cst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .token_out (token_out)
  );

  // Never write a run into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("run pushed into full queue");

  // A final byte leaves the front in its reset state for the next text.
  assert property (@(posedge clk) disable iff (rst)
    (text_in.valid && text_in.ready && text_in.final_byte) |=> front_stat.fresh)
    else $error("front state not cleared after final byte");

  // The end marker closes its run and carries no byte.
  assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && token_out.end_of_text) |->
      (token_out.last_of_run && token_out.token_byte == ChNul && !token_out.starts_token))
    else $error("malformed end marker");

endmodule
